>>> sv/kfc_pkg.sv
package kfc_pkg;

    localparam int unsigned MAX_DIGITS = 16;
    localparam int unsigned DIGIT_W    = $clog2(MAX_DIGITS + 1);
    localparam int unsigned CURSOR_MAX = 32;
    localparam int unsigned CURSOR_W   = 6;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned KEY_W      = 8;
    localparam int unsigned EV_W       = 3;
    localparam int unsigned DIV_STEPS  = DATA_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [EV_W-1:0] EV_DIGIT  = 3'd0;
    localparam logic [EV_W-1:0] EV_OPER   = 3'd1;
    localparam logic [EV_W-1:0] EV_RESULT = 3'd2;
    localparam logic [EV_W-1:0] EV_ERROR  = 3'd3;
    localparam logic [EV_W-1:0] EV_CLEAR  = 3'd4;

    localparam logic [KEY_W-1:0] KEY_ADD = 8'h2B;
    localparam logic [KEY_W-1:0] KEY_SUB = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_MUL = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_DIV = 8'h2F;
    localparam logic [KEY_W-1:0] KEY_EQ  = 8'h3D;
    localparam logic [KEY_W-1:0] KEY_CLR = 8'h43;
    localparam logic [KEY_W-1:0] KEY_0   = 8'h30;
    localparam logic [KEY_W-1:0] KEY_9   = 8'h39;
    localparam logic [KEY_W-1:0] OP_NONE = 8'h01;

    typedef struct packed {
        logic take;
        logic div_start;
        logic div_step;
        logic div_finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_div_eval;
        logic div_last;
        logic out_busy;
    } t_dp_status;

endpackage

>>> sv/kfc_if.sv
interface kfc_key_if;
    logic                      valid;
    logic                      ready;
    logic [kfc_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface kfc_res_if;
    logic                           valid;
    logic                           ready;
    logic [kfc_pkg::EV_W-1:0]       event_res;
    logic signed [kfc_pkg::DATA_W-1:0] value;
    logic [kfc_pkg::CURSOR_W-1:0]   column;
    logic [kfc_pkg::CURSOR_W-1:0]   digit_total;

    modport source (output valid, output event_res, output value, output column,
                    output digit_total, input ready);
    modport sink   (input valid, input event_res, input value, input column,
                    input digit_total, output ready);
endinterface

>>> sv/kfc_ctrl.sv
module kfc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kfc_pkg::t_dp_status i_status,
    output kfc_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !i_status.out_busy;
                if (i_in_valid && !i_status.out_busy) begin
                    o_cmd.take = 1'b1;
                    if (i_status.is_div_eval) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!i_status.out_busy) begin
                    o_cmd.div_finish = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/kfc_dp.sv
module kfc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [kfc_pkg::KEY_W-1:0]          i_key,
    input  logic                               i_out_ready,
    input  kfc_pkg::t_dp_cmd                   i_cmd,
    output kfc_pkg::t_dp_status                o_status,
    output logic                               o_out_valid,
    output logic [kfc_pkg::EV_W-1:0]           o_event_res,
    output logic signed [kfc_pkg::DATA_W-1:0]  o_value,
    output logic [kfc_pkg::CURSOR_W-1:0]       o_column,
    output logic [kfc_pkg::CURSOR_W-1:0]       o_digit_total
);

    localparam int unsigned DW = kfc_pkg::DATA_W;
    localparam int unsigned NW = kfc_pkg::DIGIT_W;
    localparam int unsigned CW = kfc_pkg::CURSOR_W;

    // calculator state
    logic [DW-1:0]             r_first,  n_first;
    logic [DW-1:0]             r_second, n_second;
    logic [NW-1:0]             r_fd,     n_fd;
    logic [NW-1:0]             r_sd,     n_sd;
    logic [kfc_pkg::KEY_W-1:0] r_op,     n_op;
    logic                      r_fdone,  n_fdone;
    logic [DW-1:0]             r_last,   n_last;
    logic [CW-1:0]             r_cur,    n_cur;

    // divider
    logic [DW-1:0]                 r_rem, n_rem;
    logic [DW-1:0]                 r_quo, n_quo;
    logic [DW-1:0]                 r_dvs, n_dvs;
    logic                          r_neg, n_neg;
    logic [kfc_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    // output register
    logic                  r_ov,  n_ov;
    logic [kfc_pkg::EV_W-1:0] r_ev, n_ev;
    logic [DW-1:0]         r_val, n_val;
    logic [CW-1:0]         r_col, n_col;
    logic [CW-1:0]         r_tot, n_tot;

    logic          is_digit;
    logic [3:0]    digit;
    logic [DW:0]   trial;
    logic [DW:0]   shifted;
    logic [DW-1:0] quo_signed;

    assign is_digit = (i_key >= kfc_pkg::KEY_0) && (i_key <= kfc_pkg::KEY_9);
    assign digit    = 4'(i_key - kfc_pkg::KEY_0);

    assign shifted    = {r_rem, r_quo[DW-1]};
    assign trial      = shifted - {1'b0, r_dvs};
    assign quo_signed = r_neg ? (DW'(0) - r_quo) : r_quo;

    assign o_status.is_div_eval = (i_key == kfc_pkg::KEY_EQ) && (r_op == kfc_pkg::KEY_DIV)
                                  && (r_second != '0);
    assign o_status.div_last    = (r_cnt == kfc_pkg::DIV_CNT_W'(kfc_pkg::DIV_STEPS - 1));
    assign o_status.out_busy    = r_ov && !i_out_ready;

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_fd     = r_fd;
        n_sd     = r_sd;
        n_op     = r_op;
        n_fdone  = r_fdone;
        n_last   = r_last;
        n_cur    = r_cur;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvs    = r_dvs;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_ov     = r_ov && !i_out_ready;
        n_ev     = r_ev;
        n_val    = r_val;
        n_col    = r_col;
        n_tot    = r_tot;

        if (i_cmd.take && !i_cmd.div_start) begin
            n_ov = 1'b1;
            if (is_digit) begin
                if (!r_fdone) begin
                    if (r_fd < NW'(kfc_pkg::MAX_DIGITS)) begin
                        n_first = (r_first << 3) + (r_first << 1) + DW'(digit);
                        n_fd    = r_fd + NW'(1);
                    end
                end else begin
                    if (r_sd < NW'(kfc_pkg::MAX_DIGITS)) begin
                        n_second = (r_second << 3) + (r_second << 1) + DW'(digit);
                        n_sd     = r_sd + NW'(1);
                    end
                end
                if (r_cur < CW'(kfc_pkg::CURSOR_MAX)) begin
                    n_cur = r_cur + CW'(1);
                end
                n_ev  = kfc_pkg::EV_DIGIT;
                n_val = DW'(digit);
                n_col = n_cur;
                n_tot = CW'(n_fd) + CW'(n_sd);
            end else if (i_key == kfc_pkg::KEY_EQ) begin
                n_ev  = kfc_pkg::EV_RESULT;
                n_tot = CW'(r_fd) + CW'(r_sd);
                priority if (r_op == kfc_pkg::KEY_ADD) begin
                    n_last = r_first + r_second;
                end else if (r_op == kfc_pkg::KEY_SUB) begin
                    n_last = r_first - r_second;
                end else if (r_op == kfc_pkg::KEY_MUL) begin
                    n_last = DW'(r_first * r_second);
                end else if (r_op == kfc_pkg::KEY_DIV) begin
                    // only a zero divisor reaches here; nonzero goes to the divider
                    n_first = '0;
                    n_fd    = '0;
                    n_fdone = 1'b0;
                    n_last  = '0;
                    n_cur   = '0;
                    n_ev    = kfc_pkg::EV_ERROR;
                    n_tot   = '0;
                end else begin
                    n_last = r_last;
                end
                n_second = '0;
                n_sd     = '0;
                n_val    = (n_ev == kfc_pkg::EV_RESULT) ? n_last : '0;
                n_col    = n_cur;
            end else if (i_key == kfc_pkg::KEY_CLR) begin
                n_first  = '0;
                n_second = '0;
                n_fd     = '0;
                n_sd     = '0;
                n_fdone  = 1'b0;
                n_last   = '0;
                n_cur    = '0;
                n_ev     = kfc_pkg::EV_CLEAR;
                n_val    = '0;
                n_col    = '0;
                n_tot    = '0;
            end else begin
                n_op    = i_key;
                n_fdone = 1'b1;
                n_cur   = '0;
                n_ev    = kfc_pkg::EV_OPER;
                n_val   = '0;
                n_col   = '0;
                n_tot   = CW'(r_fd) + CW'(r_sd);
            end
        end

        if (i_cmd.div_start) begin
            n_rem = '0;
            n_quo = r_first[DW-1] ? (DW'(0) - r_first) : r_first;
            n_dvs = r_second[DW-1] ? (DW'(0) - r_second) : r_second;
            n_neg = r_first[DW-1] ^ r_second[DW-1];
            n_cnt = '0;
        end

        if (i_cmd.div_step) begin
            if (!trial[DW]) begin
                n_rem = trial[DW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b1};
            end else begin
                n_rem = shifted[DW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt + kfc_pkg::DIV_CNT_W'(1);
        end

        if (i_cmd.div_finish) begin
            n_last   = quo_signed;
            n_second = '0;
            n_sd     = '0;
            n_ov     = 1'b1;
            n_ev     = kfc_pkg::EV_RESULT;
            n_val    = quo_signed;
            n_col    = r_cur;
            n_tot    = CW'(r_fd) + CW'(r_sd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_fd     <= '0;
            r_sd     <= '0;
            r_op     <= kfc_pkg::OP_NONE;
            r_fdone  <= 1'b0;
            r_last   <= '0;
            r_cur    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_first  <= n_first;
            r_second <= n_second;
            r_fd     <= n_fd;
            r_sd     <= n_sd;
            r_op     <= n_op;
            r_fdone  <= n_fdone;
            r_last   <= n_last;
            r_cur    <= n_cur;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_ev  <= n_ev;
        r_val <= n_val;
        r_col <= n_col;
        r_tot <= n_tot;
    end

    assign o_out_valid   = r_ov;
    assign o_event_res   = r_ev;
    assign o_value       = $signed(r_val);
    assign o_column      = r_col;
    assign o_digit_total = r_tot;

endmodule

>>> sv/keypad_four_function_calculator_top.sv
// Results: a digit, operator, clear or non-dividing '=' word shows its result in the cycle
// after it is accepted; a '=' that divides shows it after the divide and finish steps.
// Throughput: one key word per cycle while results drain; a divide holds ready low for
// its 32 quotient bits, one per cycle, plus a finish step that waits for a free output.
// Reset: synchronous, active low; clears operands, digit counts, cursor and last result,
// sets the operator to none and empties the output register.
module keypad_four_function_calculator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kfc_key_if.sink    i_key,
    kfc_res_if.source  o_res
);

    kfc_pkg::t_dp_cmd    cmd;
    kfc_pkg::t_dp_status status;
    logic                in_ready;

    // Controller: take a key word when the output register is free or draining,
    // then walk the divider for a '=' that divides by a nonzero operand.
    kfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_key.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: operand entry, the add/subtract/multiply unit, the divider and the
    // output register that holds each result word until the sink takes it.
    kfc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         (i_key.key),
        .i_out_ready   (o_res.ready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_res.valid),
        .o_event_res   (o_res.event_res),
        .o_value       (o_res.value),
        .o_column      (o_res.column),
        .o_digit_total (o_res.digit_total)
    );

    assign i_key.ready = in_ready;

endmodule

>>> sv/kfc_checker.sv
module kfc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_key_valid,
    input logic                              i_key_ready,
    input logic [kfc_pkg::KEY_W-1:0]         i_key_key,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic [kfc_pkg::EV_W-1:0]          i_res_event,
    input logic signed [kfc_pkg::DATA_W-1:0] i_res_value,
    input logic [kfc_pkg::CURSOR_W-1:0]      i_res_column,
    input logic [kfc_pkg::CURSOR_W-1:0]      i_res_total
);

    logic key_acc;
    assign key_acc = i_key_valid && i_key_ready;

    // a stalled result blocks new keys
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |-> !i_key_ready)
        else $error("key accepted while result stalled");

    // every key but '=' answers in the next cycle
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (key_acc && i_key_key != kfc_pkg::KEY_EQ) |=> i_res_valid)
        else $error("missing one-cycle result");

    // clear answers with zeros
    a_clear_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (key_acc && i_key_key == kfc_pkg::KEY_CLR) |=>
        (i_res_event == kfc_pkg::EV_CLEAR && i_res_value == 0 && i_res_column == 0
         && i_res_total == 0))
        else $error("bad clear result");

    // cursor and length stay within the display
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_column <= kfc_pkg::CURSOR_W'(kfc_pkg::CURSOR_MAX)
                         && i_res_total <= kfc_pkg::CURSOR_W'(2 * kfc_pkg::MAX_DIGITS)))
        else $error("column or length out of range");

endmodule

bind keypad_four_function_calculator_top kfc_checker u_kfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_key_valid  (i_key.valid),
    .i_key_ready  (i_key.ready),
    .i_key_key    (i_key.key),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_event  (o_res.event_res),
    .i_res_value  (o_res.value),
    .i_res_column (o_res.column),
    .i_res_total  (o_res.digit_total)
);

>>> tb/kfc_calc_monitor.sv
module kfc_calc_monitor
    import kfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    kfc_key_if   i_key_bus,
    kfc_res_if   i_res_bus,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [EV_W-1:0]     event_res;
        logic [DATA_W-1:0]   value;
        logic [CURSOR_W-1:0] column;
        logic [CURSOR_W-1:0] digit_total;
    } t_calc_word;

    t_calc_word due_words[$];
    int         fail_total = 0;

    // calculator state as the display sees it
    logic [DATA_W-1:0]   operand_a;
    logic [DATA_W-1:0]   operand_b;
    logic [DATA_W-1:0]   answer;
    logic [DIGIT_W-1:0]  count_a;
    logic [DIGIT_W-1:0]  count_b;
    logic [KEY_W-1:0]    pending_op;
    logic                on_second;
    logic [CURSOR_W-1:0] cursor_pos;

    assign o_fail_count = fail_total;

    // wipe the entry; the operator survives
    task clear_entry();
        operand_a  = '0;
        operand_b  = '0;
        count_a    = '0;
        count_b    = '0;
        on_second  = 1'b0;
        answer     = '0;
        cursor_pos = '0;
    endtask

    task automatic apply_key(input logic [KEY_W-1:0] k, output t_calc_word w);
        logic [DATA_W-1:0] digit_val;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] quot;
        w = '0;
        if (k >= KEY_0 && k <= KEY_9) begin
            digit_val = DATA_W'(k - KEY_0);
            // digits past the limit still echo and move the cursor
            if (!on_second) begin
                if (count_a < MAX_DIGITS) begin
                    operand_a = operand_a * 10 + digit_val;
                    count_a++;
                end
            end else begin
                if (count_b < MAX_DIGITS) begin
                    operand_b = operand_b * 10 + digit_val;
                    count_b++;
                end
            end
            if (cursor_pos < CURSOR_MAX) begin
                cursor_pos++;
            end
            w.event_res   = EV_DIGIT;
            w.value       = digit_val;
            w.digit_total = CURSOR_W'(count_a) + CURSOR_W'(count_b);
        end else if (k == KEY_EQ) begin
            w.event_res   = EV_RESULT;
            w.digit_total = CURSOR_W'(count_a) + CURSOR_W'(count_b);
            case (pending_op)
                KEY_ADD: answer = operand_a + operand_b;
                KEY_SUB: answer = operand_a - operand_b;
                KEY_MUL: answer = operand_a * operand_b;
                KEY_DIV: begin
                    if (operand_b == '0) begin
                        clear_entry();
                        w.event_res   = EV_ERROR;
                        w.digit_total = '0;
                    end else begin
                        // truncate toward zero on magnitudes, min / -1 wraps
                        mag_a  = operand_a[DATA_W-1] ? -operand_a : operand_a;
                        mag_b  = operand_b[DATA_W-1] ? -operand_b : operand_b;
                        quot   = mag_a / mag_b;
                        answer = (operand_a[DATA_W-1] ^ operand_b[DATA_W-1]) ? -quot : quot;
                    end
                end
                default: ;
            endcase
            operand_b = '0;
            count_b   = '0;
            if (w.event_res == EV_RESULT) begin
                w.value = answer;
            end
        end else if (k == KEY_CLR) begin
            clear_entry();
            w.event_res   = EV_CLEAR;
            w.digit_total = '0;
        end else begin
            pending_op    = k;
            on_second     = 1'b1;
            cursor_pos    = '0;
            w.event_res   = EV_OPER;
            w.digit_total = CURSOR_W'(count_a) + CURSOR_W'(count_b);
        end
        w.column = cursor_pos;
    endtask

    always @(posedge i_clk) begin
        t_calc_word got;
        t_calc_word want;
        t_calc_word fresh;
        if (!i_rst_n) begin
            clear_entry();
            pending_op = OP_NONE;
            due_words.delete();
            o_pending <= 0;
        end else begin
            // compare before queuing: a word never comes back in its own cycle
            if (i_res_bus.valid && i_res_bus.ready) begin
                got.event_res   = i_res_bus.event_res;
                got.value       = i_res_bus.value;
                got.column      = i_res_bus.column;
                got.digit_total = i_res_bus.digit_total;
                if (due_words.size() == 0) begin
                    $display("%0t: ERROR unexpected word: event %0d value %0d column %0d total %0d",
                             $time, got.event_res, $signed(got.value), got.column,
                             got.digit_total);
                    fail_total++;
                end else begin
                    want = due_words.pop_front();
                    if (got !== want) begin
                        $display("%0t: ERROR expected event %0d value %0d column %0d total %0d",
                                 $time, want.event_res, $signed(want.value), want.column,
                                 want.digit_total);
                        $display("%0t:       actual   event %0d value %0d column %0d total %0d",
                                 $time, got.event_res, $signed(got.value), got.column,
                                 got.digit_total);
                        fail_total++;
                    end
                end
            end
            if (i_key_bus.valid && i_key_bus.ready) begin
                apply_key(i_key_bus.key, fresh);
                due_words.push_back(fresh);
            end
            o_pending <= due_words.size();
        end
    end

endmodule

>>> tb/keypad_four_function_calculator_top_tb.sv
module keypad_four_function_calculator_top_tb;
    import kfc_pkg::*;

    // slowest honest run: ~2100 words, each with the longest send gap, a divide and
    // the longest receive stall, still ends inside the cycle limit
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int TAIL_CYCLES  = 40;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic res_ready  = 1'b0;
    logic quiet_mode = 1'b0;
    int   stall_left = 0;
    int   cycle_cnt  = 0;
    int   words_sent = 0;
    int   fail_count;
    int   pending_cnt;

    kfc_key_if key_bus ();
    kfc_res_if res_bus ();

    assign res_bus.ready = res_ready;

    always #2 i_clk = ~i_clk;

    keypad_four_function_calculator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_bus),
        .o_res   (res_bus)
    );

    kfc_calc_monitor u_calc_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_bus    (key_bus),
        .i_res_bus    (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    // Idle length: mostly none, sometimes a few cycles, now and then a long one.
    // Quiet stretches hold both sides busy with no idling at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode) begin
            return 0;
        end else if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Receiver: drop ready for random stalls, hold it high in quiet stretches.
    always @(posedge i_clk) begin
        if (quiet_mode) begin
            res_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            res_ready  <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            res_ready  <= 1'b1;
        end
    end

    // Watchdog: a hung handshake or a lost word ends here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one key word and hold it until the block takes it. Valid stays high
    // across back-to-back words; it only drops when a gap is chosen or the sender is parked.
    task automatic send_key(input logic [KEY_W-1:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            key_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        key_bus.valid <= 1'b1;
        key_bus.key   <= k;
        @(posedge i_clk);
        while (!key_bus.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++) begin
            send_key(KEY_0 + KEY_W'($urandom_range(0, 9)));
        end
    endtask

    // Type a 32-bit pattern in decimal, most significant digit first. Patterns
    // at or above 2^31 wrap into negative operands.
    task automatic send_number(input logic [DATA_W-1:0] v);
        logic [KEY_W-1:0]  digs [10];
        logic [DATA_W-1:0] rest;
        int                n;
        rest = v;
        n    = 0;
        do begin
            digs[n] = KEY_0 + KEY_W'(rest % 10);
            rest    = rest / 10;
            n++;
        end while (rest != 0);
        for (int i = n - 1; i >= 0; i--) begin
            send_key(digs[i]);
        end
    endtask

    // Mostly the four operations; sometimes any other non-digit code, which the
    // block stores as an operator that '=' then ignores.
    function automatic logic [KEY_W-1:0] pick_operator();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1:    k = KEY_ADD;
            2, 3:    k = KEY_SUB;
            4, 5:    k = KEY_MUL;
            6, 7, 8: k = KEY_DIV;
            default: begin
                do begin
                    k = KEY_W'($urandom_range(0, 255));
                end while ((k >= KEY_0 && k <= KEY_9) || k == KEY_EQ || k == KEY_CLR);
            end
        endcase
        return k;
    endfunction

    // One operand: empty (a zero divisor after '/'), short, a full 32-bit pattern,
    // an extreme, a run at or around the digit limit, or a lone zero.
    task automatic send_operand();
        case ($urandom_range(0, 9))
            0, 1:       ;
            2, 3, 4, 5: send_digits($urandom_range(1, 4));
            6:          send_number($urandom());
            7: begin
                case ($urandom_range(0, 4))
                    0:       send_number(32'h7FFF_FFFF);
                    1:       send_number(32'h8000_0000);
                    2:       send_number(32'hFFFF_FFFF);
                    3:       send_number(32'd1);
                    default: send_number(32'd0);
                endcase
            end
            8:          send_digits($urandom_range(MAX_DIGITS - 1, MAX_DIGITS + 3));
            default:    send_key(KEY_0);
        endcase
    endtask

    // Park the sender until every queued word has come back.
    task automatic drain_results();
        key_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    task automatic run_sequence();
        int kind;
        kind = $urandom_range(0, 19);
        quiet_mode <= ($urandom_range(0, 7) == 0);
        if (kind < 15) begin
            // well-formed entry: operand, operator, operand, '=', then maybe chain on
            if ($urandom_range(0, 4) == 0) begin
                send_key(KEY_CLR);
            end
            send_operand();
            send_key(pick_operator());
            send_operand();
            send_key(KEY_EQ);
            while ($urandom_range(0, 9) < 4) begin
                send_key(pick_operator());
                send_operand();
                send_key(KEY_EQ);
            end
        end else if (kind < 17) begin
            // long digit run to pin the cursor at its ceiling
            send_digits($urandom_range(CURSOR_MAX, CURSOR_MAX + 6));
            send_key(KEY_EQ);
        end else begin
            // raw noise over the whole key range
            repeat ($urandom_range(1, 6)) send_key(KEY_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 24) == 0) begin
            drain_results();
        end
    endtask

    initial begin
        int directed_words;
        key_bus.valid <= 1'b0;
        key_bus.key   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // '=' straight after reset: no operator, keep the zero result
        send_key(KEY_EQ);
        // divide with an empty divisor flags a math error
        send_key(KEY_DIV);
        send_key(KEY_EQ);
        // key codes at both ends of the range act as do-nothing operators
        send_key(8'h00);
        send_key(KEY_9);
        send_key(KEY_EQ);
        send_key(8'hFF);
        send_key(KEY_CLR);
        // most negative value over minus one wraps back to itself
        send_number(32'h8000_0000);
        send_key(KEY_DIV);
        send_number(32'hFFFF_FFFF);
        send_key(KEY_EQ);
        // remaining operations against a cleared second operand
        send_key(KEY_SUB);
        send_key(KEY_EQ);
        send_key(KEY_MUL);
        send_key(KEY_EQ);
        send_key(KEY_ADD);
        send_key(KEY_EQ);
        drain_results();

        directed_words = words_sent;
        while (words_sent - directed_words < RANDOM_ITEMS) begin
            run_sequence();
        end

        // drain, then give any stray words time to show up
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
